/* rtl/vwtb_pkg.sv */
// Shared types for the vertex weld table: coordinates, the sequencer states
// and the status word returned by the compare unit. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package vwtb_pkg;

	localparam int unsigned COORD_W = 32;
	localparam int unsigned TOL_W   = 31;
	localparam int unsigned AXES    = 3;
	localparam int unsigned OIDX_W  = 8;

	typedef logic [COORD_W-1:0] coord_t;
	typedef coord_t [AXES-1:0] vtx_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic valid;
		logic hit;
	} cmp_res_t;

endpackage

`default_nettype wire

/* rtl/vertex_weld_table_with_bounds_core.sv */
// Vertex weld table top level: input and output stream ports, tolerance
// register, vertex memory, scan sequencer and bounding box.
// Depends on vwtb_pkg and vwtb_match_unit.
//
// Usage: each input word carries one signed Q16.16 vertex in tdata and the
// action in tuser (0 adds or finds the vertex, 1 clears the table and box).
// The table is scanned in insertion order, one stored entry per cycle through
// a single compare unit, for the first entry within the tolerance on every
// axis. Without a match the vertex is appended, unless the table is full.
// Each input word yields exactly one output word holding the index, the
// new and full flags and the bounding box after the word.
// The scan ends at the first match or after the last stored entry, so a
// result is ready sooner for an earlier match or a smaller table; a clear
// skips the scan. A new word is taken in the cycle after the previous commit.
// A result waits in the output register while the receiver stalls; the next
// word may be accepted and scanned meanwhile, and it commits once the waiting
// result is taken. Reset empties the table, zeroes the box and sets the
// tolerance to 7. The tolerance is to be written only while the block is
// idle; the block itself does not enforce this.
`timescale 1ns / 1ps
`default_nettype none

module vertex_weld_table_with_bounds_core #(
	parameter int unsigned MAX_VERTICES = 256
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_axis_tvalid,
	output logic              s_axis_tready,
	// Fields from bit 0: x_coord[31:0], y_coord[63:32], z_coord[95:64].
	input  wire logic [95:0]  s_axis_tdata,
	// Fields from bit 0: action[0].
	input  wire logic [0:0]   s_axis_tuser,
	output logic              m_axis_tvalid,
	input  wire logic         m_axis_tready,
	// Fields from bit 0: vertex_index[7:0], min_x[39:8], min_y[71:40],
	// min_z[103:72], max_x[135:104], max_y[167:136], max_z[199:168].
	output logic [199:0]      m_axis_tdata,
	// Fields from bit 0: is_new[0], table_full[1].
	output logic [1:0]        m_axis_tuser,
	input  wire logic         cfg_wr_en,
	input  wire logic [30:0]  cfg_wr_data
);
	import vwtb_pkg::*;

	localparam int unsigned IDX_W = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
	localparam int unsigned CNT_W = $clog2(MAX_VERTICES + 1);
	localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(7);

	state_t state_q, state_nxt;

	logic [TOL_W-1:0]  tol_q;
	logic [CNT_W-1:0]  count_q;
	logic [CNT_W-1:0]  rd_idx_q;
	vtx_t              vertex_q;
	logic              clear_q;
	logic              found_q;
	logic [IDX_W-1:0]  found_idx_q;
	vtx_t              box_lo_q, box_hi_q;
	vtx_t              box_lo_nxt, box_hi_nxt;
	logic              out_valid_q;
	logic [OIDX_W-1:0] out_idx_q;
	logic              out_new_q;
	logic              out_full_q;

	vtx_t              store_q [MAX_VERTICES];
	vtx_t              entry_s1;
	logic              valid_s1;
	logic [IDX_W-1:0]  idx_s1;

	cmp_res_t          cmp_res;
	logic [IDX_W-1:0]  cmp_idx;

	logic in_accept;
	logic out_free;
	logic issue;
	logic match_hit;
	logic scan_end;
	logic commit;
	logic is_full;
	logic do_insert;

	assign in_accept = s_axis_tvalid && s_axis_tready;
	assign out_free  = !out_valid_q || m_axis_tready;
	assign match_hit = (state_q == ST_SCAN) && cmp_res.hit;
	assign scan_end  = (rd_idx_q == count_q) && !valid_s1 && !cmp_res.valid;
	assign is_full   = (count_q == CNT_W'(MAX_VERTICES));
	assign do_insert = commit && !clear_q && !found_q && !is_full;

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_accept) begin
					state_nxt = s_axis_tuser[0] ? ST_FINISH : ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (match_hit || scan_end) begin
					state_nxt = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (out_free) begin
					state_nxt = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		s_axis_tready = 1'b0;
		issue         = 1'b0;
		commit        = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_axis_tready = 1'b1;
			end
			ST_SCAN: begin
				issue = (rd_idx_q < count_q) && !match_hit;
			end
			ST_FINISH: begin
				commit = out_free;
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		for (int a = 0; a < AXES; a++) begin
			if (count_q == '0) begin
				box_lo_nxt[a] = vertex_q[a];
				box_hi_nxt[a] = vertex_q[a];
			end else begin
				box_lo_nxt[a] = ($signed(vertex_q[a]) < $signed(box_lo_q[a]))
					? vertex_q[a] : box_lo_q[a];
				box_hi_nxt[a] = ($signed(vertex_q[a]) > $signed(box_hi_q[a]))
					? vertex_q[a] : box_hi_q[a];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			tol_q       <= TOL_RESET;
			count_q     <= '0;
			rd_idx_q    <= '0;
			valid_s1    <= 1'b0;
			found_q     <= 1'b0;
			clear_q     <= 1'b0;
			box_lo_q    <= '0;
			box_hi_q    <= '0;
			out_valid_q <= 1'b0;
			out_new_q   <= 1'b0;
			out_full_q  <= 1'b0;
		end else begin
			state_q  <= state_nxt;
			valid_s1 <= issue;
			if (cfg_wr_en) begin
				tol_q <= cfg_wr_data;
			end
			if (in_accept) begin
				rd_idx_q <= '0;
				clear_q  <= s_axis_tuser[0];
				found_q  <= 1'b0;
			end else if (issue) begin
				rd_idx_q <= rd_idx_q + CNT_W'(1);
			end
			if (match_hit) begin
				found_q <= 1'b1;
			end
			if (commit) begin
				out_valid_q <= 1'b1;
				out_new_q   <= do_insert;
				out_full_q  <= !clear_q && !found_q && is_full;
				if (clear_q) begin
					count_q  <= '0;
					box_lo_q <= '0;
					box_hi_q <= '0;
				end else if (do_insert) begin
					count_q  <= count_q + CNT_W'(1);
					box_lo_q <= box_lo_nxt;
					box_hi_q <= box_hi_nxt;
				end
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			vertex_q <= s_axis_tdata;
		end
		if (match_hit) begin
			found_idx_q <= cmp_idx;
		end
		if (commit) begin
			if (clear_q || (!found_q && is_full)) begin
				out_idx_q <= '0;
			end else if (found_q) begin
				out_idx_q <= OIDX_W'(found_idx_q);
			end else begin
				out_idx_q <= OIDX_W'(count_q);
			end
		end
		if (do_insert) begin
			store_q[count_q[IDX_W-1:0]] <= vertex_q;
		end
		entry_s1 <= store_q[rd_idx_q[IDX_W-1:0]];
		idx_s1   <= rd_idx_q[IDX_W-1:0];
	end

	vwtb_match_unit #(
		.IDX_W(IDX_W)
	) u_match (
		.clk     (clk),
		.arst_n  (arst_n),
		.flush   (match_hit),
		.in_valid(valid_s1),
		.in_idx  (idx_s1),
		.entry   (entry_s1),
		.probe   (vertex_q),
		.tol     (tol_q),
		.res     (cmp_res),
		.res_idx (cmp_idx)
	);

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {box_hi_q[2], box_hi_q[1], box_hi_q[0],
		box_lo_q[2], box_lo_q[1], box_lo_q[0], out_idx_q};
	assign m_axis_tuser  = {out_full_q, out_new_q};

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_VERTICES))
		else $error("vertex count beyond table depth");

	a_commit_room: assert property (@(posedge clk) disable iff (!arst_n)
		commit |-> (!out_valid_q || m_axis_tready))
		else $error("result committed over a waiting word");

	a_new_index: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_new_q) |-> (out_idx_q == OIDX_W'(count_q - CNT_W'(1))))
		else $error("new vertex index does not match the table count");

	a_full_flag: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_full_q) |-> is_full)
		else $error("full flag reported with room in the table");

endmodule

`default_nettype wire

/* rtl/vwtb_match_unit.sv */
// Shared per-entry compare unit: registers the signed differences of one table
// entry against the probe vertex and checks all axes against the tolerance.
// Depends on vwtb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module vwtb_match_unit #(
	parameter int unsigned IDX_W = 8
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  flush,
	input  wire logic                  in_valid,
	input  wire logic [IDX_W-1:0]      in_idx,
	input  wire vwtb_pkg::vtx_t        entry,
	input  wire vwtb_pkg::vtx_t        probe,
	input  wire logic [vwtb_pkg::TOL_W-1:0] tol,
	output vwtb_pkg::cmp_res_t         res,
	output logic [IDX_W-1:0]           res_idx
);
	import vwtb_pkg::*;

	logic                      valid_s2;
	logic [IDX_W-1:0]          idx_s2;
	logic signed [COORD_W:0]   dp_s2 [AXES];
	logic signed [COORD_W:0]   dn_s2 [AXES];
	logic signed [COORD_W:0]   tol_ext;
	logic [AXES-1:0]           axis_ok;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= in_valid && !flush;
		end
	end

	always_ff @(posedge clk) begin
		idx_s2 <= in_idx;
		for (int a = 0; a < AXES; a++) begin
			dp_s2[a] <= $signed({entry[a][COORD_W-1], entry[a]})
				- $signed({probe[a][COORD_W-1], probe[a]});
			dn_s2[a] <= $signed({probe[a][COORD_W-1], probe[a]})
				- $signed({entry[a][COORD_W-1], entry[a]});
		end
	end

	// The absolute difference is below the tolerance when both signed
	// differences are.
	assign tol_ext = $signed({2'b00, tol});

	always_comb begin
		for (int a = 0; a < AXES; a++) begin
			axis_ok[a] = (dp_s2[a] < tol_ext) && (dn_s2[a] < tol_ext);
		end
	end

	assign res.valid = valid_s2;
	assign res.hit   = valid_s2 && (&axis_ok);
	assign res_idx   = idx_s2;

endmodule

`default_nettype wire
